[rtl/core/edtc_pkg.sv]
`timescale 1ns / 1ps

package edtc_pkg;

  typedef enum logic {
    ACT_DECODE = 1'b0,
    ACT_ENCODE = 1'b1
  } action_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] seconds_in;
    logic [6:0]  year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } req_t;

  typedef struct packed {
    logic [31:0] seconds_out;
    logic [6:0]  year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        out_of_range;
  } rsp_t;

  localparam int PIPE_DEPTH = 7;

  localparam logic [31:0] SECS_PER_DAY   = 32'd86400;
  localparam logic [16:0] SECS_PER_HOUR  = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN   = 12'd60;
  localparam logic [31:0] LAST_SECOND    = 32'd3786911999;
  localparam logic [6:0]  LAST_YEAR      = 7'd119;
  localparam logic [3:0]  LAST_MONTH     = 4'd11;
  localparam logic [4:0]  LAST_HOUR      = 5'd23;
  localparam logic [5:0]  LAST_MIN_SEC   = 6'd59;
  localparam logic [15:0] DAYS_PER_GROUP = 16'd1461;
  localparam logic [10:0] DAYS_LEAP_YEAR = 11'd366;
  localparam logic [10:0] DAYS_PER_YEAR  = 11'd365;

  // reciprocals, exact over the operand ranges used
  localparam logic [25:0] DAY_RECIP   = 26'd50903317;  // 2^35 / 675
  localparam logic [15:0] GROUP_RECIP = 16'd45934;     // 2^26 / 1461
  localparam logic [16:0] HOUR_RECIP  = 17'd74566;     // 2^28 / 3600
  localparam logic [12:0] MIN_RECIP   = 13'd4370;      // 2^18 / 60

  function automatic logic [8:0] month_start(input logic leap, input logic [3:0] m);
    logic [8:0] base;
    unique case (m)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return (leap && m >= 4'd2 && m <= LAST_MONTH) ? base + 9'd1 : base;
  endfunction

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1:                    len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

[rtl/core/epoch_date_time_converter.sv]
`timescale 1ns / 1ps

// Converts between seconds since 1980-01-01 00:00:00 and zero-based calendar
// fields. Each request word on req carries an action: decode splits
// seconds_in into year, month, day, hour, minute and second; encode packs the
// calendar fields into seconds_out. Out-of-range input (past 2099 or a bad
// field) sets out_of_range with all other result fields zero.
// Each accepted request yields exactly one response word on rsp, in order.
// The datapath has seven register stages (input, five arithmetic stages,
// output); rsp_valid rises once a word has passed through all of them.
// The pipeline takes one word per cycle while rsp_ready is high.
// When rsp holds an untaken word, the whole pipeline freezes and req_ready
// drops; it rises again in the cycle rsp_ready returns.
// Reset (rst, synchronous) empties the pipeline; words in flight are dropped.

module epoch_date_time_converter import edtc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic [PIPE_DEPTH-1:0] vld;
  logic                  en;

  assign en        = !vld[PIPE_DEPTH-1] || rsp_ready;
  assign req_ready = en;
  assign rsp_valid = vld[PIPE_DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_DEPTH-2:0], req_valid};
    end
  end

  edtc_pipe u_pipe (
    .clk (clk),
    .en  (en),
    .req (req),
    .rsp (rsp)
  );

`ifndef ASSERT_OFF
  a_oor_clear : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.out_of_range |->
      rsp.seconds_out == '0 && rsp.year_out == '0 && rsp.month_out == '0 &&
      rsp.day_out == '0 && rsp.hour_out == '0 && rsp.minute_out == '0 &&
      rsp.second_out == '0)
    else $error("out_of_range word carries nonzero fields");

  a_one_dir : assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.seconds_out == '0 ||
      (rsp.year_out == '0 && rsp.month_out == '0 && rsp.day_out == '0 &&
       rsp.hour_out == '0 && rsp.minute_out == '0 && rsp.second_out == '0))
    else $error("encode and decode fields both set");

  a_ranges : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.out_of_range |->
      rsp.month_out <= LAST_MONTH && rsp.hour_out <= LAST_HOUR &&
      rsp.minute_out <= LAST_MIN_SEC && rsp.second_out <= LAST_MIN_SEC &&
      rsp.year_out <= LAST_YEAR && rsp.seconds_out <= LAST_SECOND)
    else $error("decoded field out of range");
`endif

endmodule

[rtl/core/edtc_pipe.sv]
`timescale 1ns / 1ps

module edtc_pipe import edtc_pkg::*; (
  input  logic clk,
  input  logic en,
  input  req_t req,
  output rsp_t rsp
);

  typedef struct packed {
    req_t        req;
    logic [15:0] days;
    logic [16:0] tod;
    logic [5:0]  grp;
    logic [10:0] rem;
    logic [4:0]  hour;
    logic [11:0] hrem;
    logic [1:0]  yoff;
    logic [8:0]  doy;
    logic        leap;
    logic [5:0]  minute;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [6:0]  year;
    logic        enc_bad;
    logic [15:0] enc_days;
    logic [16:0] hms;
    logic [31:0] total;
  } pipe_t;

  req_t  p0;
  pipe_t p1, p2, p3, p4, p5;
  pipe_t p1_next, p2_next, p3_next, p4_next, p5_next;
  rsp_t  rsp_next;

  logic [50:0] day_prod;
  logic [31:0] grp_prod;
  logic [33:0] hour_prod;
  logic [24:0] min_prod;
  logic [31:0] day_secs;
  logic [10:0] rem_y;
  logic        leap_e;
  logic [7:0]  year_p3;
  logic [3:0]  mcount;
  logic [5:0]  second;

  // day count, encode prep
  always_comb begin
    p1_next     = '0;
    p1_next.req = p0;
    day_prod    = 51'(p0.seconds_in[31:7]) * 51'(DAY_RECIP);
    p1_next.days = day_prod[50:35];
    leap_e      = (p0.year_in[1:0] == 2'd0);
    year_p3     = 8'(p0.year_in) + 8'd3;
    p1_next.enc_bad = (p0.year_in > LAST_YEAR) || (p0.month_in > LAST_MONTH) ||
                      (p0.hour_in > LAST_HOUR) || (p0.minute_in > LAST_MIN_SEC) ||
                      (p0.second_in > LAST_MIN_SEC) ||
                      (p0.day_in >= month_len(leap_e, p0.month_in));
    p1_next.enc_days = 16'(p0.year_in) * 16'd365 + 16'(year_p3[7:2]) +
                       16'(month_start(leap_e, p0.month_in)) + 16'(p0.day_in);
    p1_next.hms = 17'(p0.hour_in) * SECS_PER_HOUR + 17'(p0.minute_in) * 17'd60 +
                  17'(p0.second_in);
  end

  // time of day, four-year group
  always_comb begin
    p2_next     = p1;
    day_secs    = 32'(p1.days) * SECS_PER_DAY;
    p2_next.tod = 17'(p1.req.seconds_in - day_secs);
    grp_prod    = 32'(p1.days) * 32'(GROUP_RECIP);
    p2_next.grp = grp_prod[31:26];
  end

  // day within group, hour, encoded total
  always_comb begin
    p3_next      = p2;
    p3_next.rem  = 11'(p2.days - 16'(p2.grp) * DAYS_PER_GROUP);
    hour_prod    = 34'(p2.tod) * 34'(HOUR_RECIP);
    p3_next.hour = hour_prod[32:28];
    p3_next.total = 32'(p2.enc_days) * SECS_PER_DAY + 32'(p2.hms);
  end

  // year within group, seconds within hour
  always_comb begin
    p4_next      = p3;
    p4_next.hrem = 12'(p3.tod - 17'(p3.hour) * SECS_PER_HOUR);
    rem_y        = p3.rem - DAYS_LEAP_YEAR;
    if (p3.rem < DAYS_LEAP_YEAR) begin
      p4_next.yoff = 2'd0;
      p4_next.doy  = 9'(p3.rem);
      p4_next.leap = 1'b1;
    end else if (rem_y < DAYS_PER_YEAR) begin
      p4_next.yoff = 2'd1;
      p4_next.doy  = 9'(rem_y);
      p4_next.leap = 1'b0;
    end else if (rem_y < 11'd730) begin
      p4_next.yoff = 2'd2;
      p4_next.doy  = 9'(rem_y - DAYS_PER_YEAR);
      p4_next.leap = 1'b0;
    end else begin
      p4_next.yoff = 2'd3;
      p4_next.doy  = 9'(rem_y - 11'd730);
      p4_next.leap = 1'b0;
    end
  end

  // month, day of month, minute, year
  always_comb begin
    p5_next = p4;
    mcount  = 4'd0;
    for (int k = 1; k <= 11; k++) begin
      if (month_start(p4.leap, 4'(k)) <= p4.doy) begin
        mcount = mcount + 4'd1;
      end
    end
    p5_next.month  = mcount;
    p5_next.day    = 5'(p4.doy - month_start(p4.leap, mcount));
    min_prod       = 25'(p4.hrem) * 25'(MIN_RECIP);
    p5_next.minute = min_prod[23:18];
    p5_next.year   = 7'({p4.grp, 2'b00} + 8'(p4.yoff));
  end

  // second, result select
  always_comb begin
    rsp_next = '0;
    second   = 6'(p5.hrem - 12'(p5.minute) * SECS_PER_MIN);
    if (p5.req.action == ACT_ENCODE) begin
      if (p5.enc_bad) begin
        rsp_next.out_of_range = 1'b1;
      end else begin
        rsp_next.seconds_out = p5.total;
      end
    end else if (p5.req.seconds_in > LAST_SECOND) begin
      rsp_next.out_of_range = 1'b1;
    end else begin
      rsp_next.year_out   = p5.year;
      rsp_next.month_out  = p5.month;
      rsp_next.day_out    = p5.day;
      rsp_next.hour_out   = p5.hour;
      rsp_next.minute_out = p5.minute;
      rsp_next.second_out = second;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= req;
      p1  <= p1_next;
      p2  <= p2_next;
      p3  <= p3_next;
      p4  <= p4_next;
      p5  <= p5_next;
      rsp <= rsp_next;
    end
  end

endmodule
